/* src/vector_pid_controller_core_macros.svh */
// Assertion macros shared by the vector PID controller RTL.
// No dependencies; the including module must provide clk and rst.
`ifndef VECTOR_PID_CONTROLLER_CORE_MACROS_SVH
`define VECTOR_PID_CONTROLLER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPID_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/vpid_pkg.sv */
// Shared widths, register codes and control types of the vector PID controller.
// No dependencies; used by the interfaces, the lanes, the divider and the top level.
`default_nettype none

package vpid_pkg;

  localparam int ERR_W         = 16;
  localparam int DT_W          = 16;
  localparam int GAIN_W        = 16;
  localparam int ACC_W         = 32;
  localparam int DRV_W         = 32;
  localparam int INT_SHIFT     = 4;
  localparam int FRAC_SHIFT    = 20;
  localparam int NUM_W         = DT_W + FRAC_SHIFT;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = NUM_W / BITS_PER_STEP;
  localparam int CNT_W         = $clog2(DIV_STEPS);
  localparam int PROD_W        = GAIN_W + ACC_W;
  localparam int OUT_SHIFT     = 8;
  localparam int SUM_W         = PROD_W + 2;
  localparam int CFG_IDX_W     = 2;

  localparam logic [DRV_W-1:0] DRV_MAX = {1'b0, {(DRV_W-1){1'b1}}};
  localparam logic [DRV_W-1:0] DRV_MIN = {1'b1, {(DRV_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

  typedef struct packed {
    logic signed [GAIN_W-1:0] p;
    logic signed [GAIN_W-1:0] i;
    logic signed [GAIN_W-1:0] d;
  } gains_t;

  // One strobe per phase of the lane sequence, driven by the top level.
  typedef struct packed {
    logic start;
    logic clr;
    logic mul1;
    logic integ;
    logic div_step;
    logic dsat;
    logic mul2;
    logic sum;
    logic fin;
  } ctrl_t;

endpackage

`default_nettype wire

/* src/vpid_sample_if.sv */
// Input channel of the vector PID controller: per-lane errors, elapsed time, clear.
// Depends on vpid_pkg for the field widths.
`default_nettype none

interface vpid_sample_if #(
  parameter int LANES = 4
);
  import vpid_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [LANES-1:0][ERR_W-1:0] error;
  logic [DT_W-1:0]             elapsed_time;
  logic                        clear;

  modport source (output valid, output error, output elapsed_time, output clear,
                  input ready);
  modport sink   (input valid, input error, input elapsed_time, input clear,
                  output ready);
endinterface

`default_nettype wire

/* src/vpid_drive_if.sv */
// Output channel of the vector PID controller: one drive value per lane.
// Depends on vpid_pkg for the field width.
`default_nettype none

interface vpid_drive_if #(
  parameter int LANES = 4
);
  import vpid_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [LANES-1:0][DRV_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

/* src/vpid_div.sv */
// Restoring divider of one lane: mag * 2^20 / dt, two quotient bits a cycle on step.
// Depends on vpid_pkg; the lane sequences load and step.
`default_nettype none

module vpid_div (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  logic [vpid_pkg::DT_W-1:0]  mag,
  input  logic [vpid_pkg::DT_W-1:0]  dt,
  output logic [vpid_pkg::NUM_W-1:0] quot
);
  import vpid_pkg::*;

  logic [DT_W-1:0]  rem;
  logic [NUM_W-1:0] nq;
  logic [DT_W-1:0]  rem_next;
  logic [NUM_W-1:0] nq_next;

  // The numerator shifts out of the top of nq while quotient bits enter at the bottom.
  always_comb begin
    logic [DT_W:0] t;
    rem_next = rem;
    nq_next  = nq;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      t = {rem_next, nq_next[NUM_W-1]};
      if (t >= {1'b0, dt}) begin
        t       = t - {1'b0, dt};
        nq_next = {nq_next[NUM_W-2:0], 1'b1};
      end else begin
        nq_next = {nq_next[NUM_W-2:0], 1'b0};
      end
      rem_next = t[DT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      nq  <= {mag, {FRAC_SHIFT{1'b0}}};
    end else if (step) begin
      rem <= rem_next;
      nq  <= nq_next;
    end
  end

  assign quot = nq;

endmodule

`default_nettype wire

/* src/vpid_lane.sv */
// One PID lane: integral and previous-error stores, derivative divider, gain products.
// Depends on vpid_pkg and vpid_div; sequenced by the top level through ctrl_t.
`default_nettype none

module vpid_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  vpid_pkg::ctrl_t           ctrl,
  input  vpid_pkg::gains_t          gains,
  input  logic [vpid_pkg::ERR_W-1:0] error,
  input  logic [vpid_pkg::DT_W-1:0]  elapsed_time,
  output logic [vpid_pkg::DRV_W-1:0] drive
);
  import vpid_pkg::*;

  logic signed [ERR_W-1:0]         err_cur;
  logic signed [ERR_W-1:0]         e_r;
  logic signed [ERR_W-1:0]         last_error;
  logic signed [ACC_W-1:0]         integral;
  logic [DT_W-1:0]                 dt_fix;
  logic [DT_W-1:0]                 dt_r;
  logic signed [ERR_W:0]           diff;
  logic signed [ERR_W:0]           diff_neg;
  logic [ERR_W-1:0]                diff_mag;
  logic                            neg;
  logic [NUM_W-1:0]                quot;
  logic signed [ERR_W+DT_W:0]      prod_int;
  logic signed [ERR_W+DT_W-INT_SHIFT:0] int_step;
  logic signed [ACC_W:0]           int_sum;
  logic [ACC_W-1:0]                int_sat;
  logic signed [ERR_W+GAIN_W-1:0]  prod_p;
  logic signed [ACC_W-1:0]         deriv;
  logic [ACC_W-1:0]                deriv_sat;
  logic signed [PROD_W-1:0]        prod_i;
  logic signed [PROD_W-1:0]        prod_d;
  logic signed [SUM_W-1:0]         total;
  logic [DRV_W-1:0]                drive_sat;

  assign err_cur  = $signed(error);
  assign dt_fix   = (elapsed_time == '0) ? DT_W'(1) : elapsed_time;
  assign diff     = {err_cur[ERR_W-1], err_cur} - {last_error[ERR_W-1], last_error};
  assign diff_neg = -diff;
  assign diff_mag = diff[ERR_W] ? diff_neg[ERR_W-1:0] : diff[ERR_W-1:0];

  vpid_div u_div (
    .clk  (clk),
    .load (ctrl.start && !ctrl.clr),
    .step (ctrl.div_step),
    .mag  (diff_mag),
    .dt   (dt_r),
    .quot (quot)
  );

  // Dropping the low bits of the signed product is the floor shift to Q16.16.
  assign int_step = prod_int[ERR_W+DT_W:INT_SHIFT];
  assign int_sum  = {integral[ACC_W-1], integral} + (ACC_W+1)'(int_step);
  assign int_sat  = (int_sum[ACC_W] != int_sum[ACC_W-1]) ?
                    (int_sum[ACC_W] ? DRV_MIN : DRV_MAX) : int_sum[ACC_W-1:0];

  // The quotient is a magnitude; a negative result may reach 2^31 before it clips.
  always_comb begin
    if (neg) begin
      if ((|quot[NUM_W-1:ACC_W]) || (quot[ACC_W-1] && (|quot[ACC_W-2:0]))) begin
        deriv_sat = DRV_MIN;
      end else begin
        deriv_sat = -quot[ACC_W-1:0];
      end
    end else begin
      if (|quot[NUM_W-1:ACC_W-1]) begin
        deriv_sat = DRV_MAX;
      end else begin
        deriv_sat = quot[ACC_W-1:0];
      end
    end
  end

  assign drive_sat = (&total[SUM_W-1:DRV_W+OUT_SHIFT-1]) ||
                     !(|total[SUM_W-1:DRV_W+OUT_SHIFT-1]) ?
                     total[DRV_W+OUT_SHIFT-1:OUT_SHIFT] :
                     (total[SUM_W-1] ? DRV_MIN : DRV_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      last_error <= '0;
    end else if (ctrl.start) begin
      if (ctrl.clr) begin
        integral   <= '0;
        last_error <= '0;
      end else begin
        last_error <= err_cur;
      end
    end else if (ctrl.integ) begin
      integral <= $signed(int_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      e_r  <= err_cur;
      dt_r <= dt_fix;
      neg  <= diff[ERR_W];
      if (ctrl.clr) begin
        drive <= '0;
      end
    end
    if (ctrl.mul1) begin
      prod_int <= e_r * $signed({1'b0, dt_r});
      prod_p   <= $signed(gains.p) * e_r;
    end
    if (ctrl.dsat) begin
      deriv <= $signed(deriv_sat);
    end
    if (ctrl.mul2) begin
      prod_i <= $signed(gains.i) * integral;
      prod_d <= $signed(gains.d) * deriv;
    end
    if (ctrl.sum) begin
      total <= (SUM_W'(prod_p) <<< OUT_SHIFT) + SUM_W'(prod_i) + SUM_W'(prod_d);
    end
    if (ctrl.fin) begin
      drive <= drive_sat;
    end
  end

endmodule

`default_nettype wire

/* src/vector_pid_controller_core.sv */
// Top level of the vector PID controller: gain registers, lane sequencer, output register.
// Depends on vpid_pkg, vpid_sample_if, vpid_drive_if, vpid_lane and the assertion macros.
//
//   channel   direction  beat contents
//   sample    in         error per lane, elapsed_time, clear
//   result    out        drive per lane
//   cfg_*     in         gain write: index 0 = p, 1 = i, 2 = d
//
// A sample passes from its beat through a load of the lane registers, the per-lane
// radix-4 divider for the derivative (36 quotient bits), the saturation, gain product
// and sum states, the lane drive register and the output register. A clear sample skips
// the divider and arithmetic states. Synchronous reset zeroes gains and lane stores at once.
// While a result waits for the sink, the next sample is accepted and computed; its
// result then waits in the lanes until the output register frees.
`default_nettype none

module vector_pid_controller_core #(
  parameter int LANES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [vpid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vpid_pkg::GAIN_W-1:0]    cfg_data,
  vpid_sample_if.sink                   sample,
  vpid_drive_if.source                  result
);
  import vpid_pkg::*;

`include "vector_pid_controller_core_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DSAT,
    S_MUL2,
    S_SUM,
    S_FIN,
    S_HOLD
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            cnt;
  gains_t                      gains;
  ctrl_t                       ctrl;
  logic                        sample_beat;
  logic [LANES-1:0][DRV_W-1:0] lane_drive;

  assign sample.ready = (state == S_IDLE) && !rst;
  assign sample_beat  = sample.valid && sample.ready;

  always_comb begin
    ctrl          = '0;
    ctrl.start    = sample_beat;
    ctrl.clr      = sample.clear;
    ctrl.div_step = (state == S_DIV);
    ctrl.mul1     = (state == S_DIV) && (cnt == CNT_W'(0));
    ctrl.integ    = (state == S_DIV) && (cnt == CNT_W'(1));
    ctrl.dsat     = (state == S_DSAT);
    ctrl.mul2     = (state == S_MUL2);
    ctrl.sum      = (state == S_SUM);
    ctrl.fin      = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GAIN_P: gains.p <= cfg_data;
        CFG_GAIN_I: gains.i <= cfg_data;
        CFG_GAIN_D: gains.d <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    vpid_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .gains        (gains),
      .error        (sample.error[k]),
      .elapsed_time (sample.elapsed_time),
      .drive        (lane_drive[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result.valid <= 1'b0;
    end else begin
      // In the hold state the output register is refilled at the same edge it drains.
      if (result.valid && result.ready && (state != S_HOLD)) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_beat) begin
            cnt   <= '0;
            state <= sample.clear ? S_HOLD : S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_DSAT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DSAT: state <= S_MUL2;
        S_MUL2: state <= S_SUM;
        S_SUM:  state <= S_FIN;
        S_FIN:  state <= S_HOLD;
        S_HOLD: begin
          // The merged result moves out once the output register is empty or draining.
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            result.drive <= lane_drive;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VPID_ASSERT_NEXT(a_busy_after_beat, sample_beat, !sample.ready, "sample taken while busy")
  `VPID_ASSERT_NEXT(a_clear_short, sample_beat && sample.clear, state == S_HOLD, "clear path")
  `VPID_ASSERT_SAME(a_div_count, state == S_DIV, cnt <= CNT_W'(DIV_STEPS - 1), "div overrun")
  `VPID_ASSERT_NEXT(a_hold_loads, state == S_HOLD && !result.valid, result.valid, "no load")

endmodule

`default_nettype wire

/* tb/vector_pid_controller_core_tb.sv */
// Self-checking testbench for vector_pid_controller_core: random and directed samples,
// gain writes between phases, and an in-bench PID predictor that checks every drive value.
// Depends on vpid_pkg, vpid_sample_if, vpid_drive_if and the controller RTL.
`timescale 1ns / 1ps

module vector_pid_controller_core_tb;
  import vpid_pkg::*;

  localparam int LANES         = 4;
  localparam int RANDOM_SETS   = 6;
  localparam int ITEMS_PER_SET = 125;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;

  typedef struct packed {
    logic [LANES-1:0][ERR_W-1:0] error;
    logic [DT_W-1:0]             elapsed_time;
    logic                        clear;
  } sample_t;

  typedef logic [LANES-1:0][DRV_W-1:0] drive_vec_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;

  vpid_sample_if #(.LANES(LANES)) sample_bus ();
  vpid_drive_if  #(.LANES(LANES)) drive_bus ();

  vector_pid_controller_core #(.LANES(LANES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_bus),
    .result    (drive_bus)
  );

  sample_t    pending [$];
  drive_vec_t drive_expect [$];
  sample_t    on_bus;
  gains_t     gain_set;
  longint     integral_acc [LANES];
  longint     prev_error [LANES];
  bit         steady;
  int         samples_queued;
  int         clears_queued;
  int         results_seen;
  int         mismatches;
  int         cycle_count;
  int         settings_used;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp32(input longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  // Advances the per-lane integral and previous-error state by one sample and
  // returns the drive values the controller should produce for it.
  function automatic drive_vec_t pid_step(input sample_t s);
    drive_vec_t drv;
    longint     dt;
    longint     e;
    longint     kp;
    longint     ki;
    longint     kd;
    longint     d_term;
    longint     total;
    drv = '0;
    dt  = longint'(s.elapsed_time);
    if (dt == 0) dt = 1;
    kp = longint'($signed(gain_set.p));
    ki = longint'($signed(gain_set.i));
    kd = longint'($signed(gain_set.d));
    for (int k = 0; k < LANES; k++) begin
      if (s.clear) begin
        integral_acc[k] = 0;
        prev_error[k]   = 0;
      end else begin
        e = longint'($signed(s.error[k]));
        integral_acc[k] = clamp32(integral_acc[k] + ((e * dt) >>> INT_SHIFT));
        // Signed division truncates toward zero, as the derivative requires.
        d_term = clamp32(((e - prev_error[k]) * (64'sd1 << FRAC_SHIFT)) / dt);
        total  = kp * e * 256 + ki * integral_acc[k] + kd * d_term;
        drv[k] = DRV_W'(clamp32(total >>> OUT_SHIFT));
        prev_error[k] = e;
      end
    end
    return drv;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_sample(input sample_t s);
    pending.push_back(s);
    samples_queued++;
    if (s.clear) clears_queued++;
  endtask

  function automatic sample_t make_sample(input logic [ERR_W-1:0] e0, e1, e2, e3,
                                          input logic [DT_W-1:0] dt, input logic clr);
    sample_t s;
    s.error[0]     = e0;
    s.error[1]     = e1;
    s.error[2]     = e2;
    s.error[3]     = e3;
    s.elapsed_time = dt;
    s.clear        = clr;
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_GAIN_P: gain_set.p = val;
      CFG_GAIN_I: gain_set.i = val;
      CFG_GAIN_D: gain_set.d = val;
      default: ;
    endcase
  endtask

  // The spare index goes first so that an ignored write lands just before the real ones.
  task automatic set_gains(input logic [GAIN_W-1:0] gp, gi, gd);
    write_reg(CFG_SPARE, GAIN_W'($urandom));
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (results_seen < samples_queued) @(posedge clk);
  endtask

  task automatic load_random(input int n);
    sample_t s;
    int      made;
    int      pick;
    int      len;
    int      walk [LANES];
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(4, 20);
      if (pick >= 45 && pick < 60) len = $urandom_range(14, 30);
      if (pick >= 90) len = 1;
      for (int k = 0; k < LANES; k++) walk[k] = int'($urandom_range(0, 65535)) - 32768;
      for (int j = 0; j < len && made < n; j++) begin
        s.clear = 1'b0;
        if (pick < 45) begin
          // Slowly moving errors at a plausible loop interval.
          for (int k = 0; k < LANES; k++) begin
            walk[k] += int'($urandom_range(0, 1024)) - 512;
            if (walk[k] > 32767) walk[k] = 32767;
            if (walk[k] < -32768) walk[k] = -32768;
            s.error[k] = ERR_W'(walk[k]);
          end
          s.elapsed_time = DT_W'($urandom_range(16'h0080, 16'h2000));
        end else if (pick < 60) begin
          // Large errors of a fixed sign over long intervals drive the integral to its rails.
          for (int k = 0; k < LANES; k++) begin
            s.error[k] = (walk[k] < 0) ? ERR_W'($urandom_range(16'h8000, 16'h9FFF))
                                       : ERR_W'($urandom_range(16'h6000, 16'h7FFF));
          end
          s.elapsed_time = DT_W'($urandom_range(16'hC000, 16'hFFFF));
        end else if (pick < 75) begin
          // Error jumps over the shortest intervals push the derivative into saturation.
          for (int k = 0; k < LANES; k++) s.error[k] = ERR_W'($urandom);
          s.elapsed_time = DT_W'($urandom_range(0, 3));
        end else if (pick < 90) begin
          for (int k = 0; k < LANES; k++) s.error[k] = ERR_W'($urandom);
          s.elapsed_time = ($urandom_range(0, 9) == 0) ? '0 : DT_W'($urandom);
          s.clear        = ($urandom_range(0, 15) == 0);
        end else begin
          for (int k = 0; k < LANES; k++) s.error[k] = ERR_W'($urandom);
          s.elapsed_time = DT_W'($urandom);
          s.clear        = 1'b1;
        end
        queue_sample(s);
        made++;
      end
    end
  endtask

  // Driver: offers the next pending sample on a free channel, at random unless steady.
  always @(posedge clk) begin
    if (rst) begin
      sample_bus.valid <= 1'b0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        drive_expect.push_back(pid_step(on_bus));
      end
      if (!sample_bus.valid || sample_bus.ready) begin
        if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
          on_bus = pending.pop_front();
          sample_bus.valid        <= 1'b1;
          sample_bus.error        <= on_bus.error;
          sample_bus.elapsed_time <= on_bus.elapsed_time;
          sample_bus.clear        <= on_bus.clear;
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    drive_vec_t want;
    if (rst) begin
      drive_bus.ready <= 1'b0;
    end else begin
      if (drive_bus.valid && drive_bus.ready) begin
        results_seen++;
        if (drive_expect.size() == 0) begin
          flag_mismatch($sformatf("result %h arrived with nothing expected", drive_bus.drive));
        end else begin
          want = drive_expect.pop_front();
          for (int k = 0; k < LANES; k++) begin
            if (drive_bus.drive[k] !== want[k]) begin
              flag_mismatch($sformatf("result %0d lane %0d: got %h, expected %h",
                                      results_seen, k, drive_bus.drive[k], want[k]));
            end
          end
        end
      end
      drive_bus.ready <= steady || ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d of %0d results seen",
               cycle_count, results_seen, samples_queued);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    sample_bus.valid        = 1'b0;
    sample_bus.error        = '0;
    sample_bus.elapsed_time = '0;
    sample_bus.clear        = 1'b0;
    drive_bus.ready         = 1'b0;
    steady                  = 1'b0;
    gain_set                = '0;
    samples_queued          = 0;
    clears_queued           = 0;
    results_seen            = 0;
    mismatches              = 0;
    cycle_count             = 0;
    settings_used           = 0;
    for (int k = 0; k < LANES; k++) begin
      integral_acc[k] = 0;
      prev_error[k]   = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed samples at unity gains.
    set_gains(16'h0100, 16'h0100, 16'h0100);
    queue_sample(make_sample(16'h1234, 16'h8765, 16'h7FFF, 16'h8000, 16'h0040, 1'b1));
    queue_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    queue_sample(make_sample(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 1'b0));
    queue_sample(make_sample(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0001, 1'b0));
    queue_sample(make_sample(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0));
    queue_sample(make_sample(16'h0000, 16'h0000, 16'h0100, 16'hFF00, 16'hFFFF, 1'b0));
    queue_sample(make_sample(16'h1234, 16'hEDCB, 16'h5555, 16'hAAAA, 16'h8000, 1'b0));
    // Repeated full-scale errors at the longest interval wind every integral up to a rail.
    for (int j = 0; j < 17; j++) begin
      queue_sample(make_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0));
    end
    queue_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    wait_drained();

    for (int p = 0; p < RANDOM_SETS; p++) begin
      case (p)
        0: set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF);
        1: set_gains(16'h8000, 16'h8000, 16'h8000);
        2: set_gains(16'h7FFF, 16'h8000, 16'h0000);
        3: set_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
        4: set_gains(16'h0000, 16'h0000, 16'h0000);
        default: set_gains(GAIN_W'(int'($urandom_range(0, 2048)) - 1024),
                           GAIN_W'(int'($urandom_range(0, 2048)) - 1024),
                           GAIN_W'(int'($urandom_range(0, 2048)) - 1024));
      endcase
      steady = (p == 1);
      if (p == 3) begin
        // The sender holds off halfway until every outstanding result is back.
        load_random(ITEMS_PER_SET / 2);
        wait_drained();
        load_random(ITEMS_PER_SET - ITEMS_PER_SET / 2);
      end else begin
        load_random(ITEMS_PER_SET);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (drive_expect.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", drive_expect.size()));
    end
    $display("Ran %0d samples (%0d clears) and checked %0d results over %0d gain settings,",
             samples_queued, clears_queued, results_seen, settings_used);
    $display("including full-scale, mixed-sign and zero gains; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
